// File: rtl/core/cga_pkg.sv
// Package for the generational cell allocator: field widths, default page size,
// status and action codes, cell flag bits. No dependencies.
package cga_pkg;

    localparam int CELL_COUNT_DEF = 128;

    localparam int IDX_PORT_W   = 7;
    localparam int EPOCH_W      = 16;
    localparam int FLAGS_W      = 4;
    localparam int STATUS_W     = 2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [FLAGS_W-1:0] FLAG_OBJ_SHARED    = 4'h2;
    localparam logic [FLAGS_W-1:0] FLAG_SHARED_EXPORT = 4'h4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NONE_ALLOC = 2'd2,
        ST_BAD_INDEX  = 2'd3
    } t_status;

endpackage

// File: rtl/core/cga_if.sv
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on cga_pkg for field widths.
interface cga_req_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [cga_pkg::IDX_PORT_W-1:0] cell_index;

    modport source (output valid, action, cell_index, input ready);
    modport sink   (input valid, action, cell_index, output ready);
endinterface

interface cga_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [cga_pkg::STATUS_W-1:0]   status;
    logic [cga_pkg::IDX_PORT_W-1:0] cell_index_out;
    logic [cga_pkg::EPOCH_W-1:0]    cell_epoch;
    logic [cga_pkg::FLAGS_W-1:0]    cell_flags;
    logic [cga_pkg::IDX_PORT_W-1:0] free_count;

    modport source (output valid, status, cell_index_out, cell_epoch, cell_flags, free_count,
                    input ready);
    modport sink   (input valid, status, cell_index_out, cell_epoch, cell_flags, free_count,
                    output ready);
endinterface

// File: rtl/core/cga_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/cga_init.sv
// Post-reset sweep that chains cells 1..CELL_COUNT-1 into the free list
// and clears every epoch, one cell per cycle. Depends on cga_pkg.
module cga_init #(
    parameter int CELL_COUNT = cga_pkg::CELL_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    output logic                          o_wr_en,
    output logic [$clog2(CELL_COUNT)-1:0] o_wr_addr,
    output logic [$clog2(CELL_COUNT)-1:0] o_wr_link,
    output logic                          o_done
);

    localparam int IDX_W = $clog2(CELL_COUNT);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(CELL_COUNT - 1);

    logic [IDX_W-1:0] r_ptr;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_done <= 1'b0;
        end else if (!r_done) begin
            if (r_ptr == LAST) begin
                r_done <= 1'b1;
            end else begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    assign o_wr_en   = !r_done;
    assign o_wr_addr = r_ptr;
    // null for cell 0 and the tail of the chain
    assign o_wr_link = (r_ptr == '0 || r_ptr == LAST) ? '0 : r_ptr + 1'b1;
    assign o_done    = r_done;

endmodule

// File: rtl/core/cga_ctrl.sv
// Allocate/free sequencer: reads link and epoch of one cell, then updates the
// free list and registers the response. Depends on cga_pkg and cga_if.
module cga_ctrl #(
    parameter int CELL_COUNT = cga_pkg::CELL_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_init_done,
    cga_req_if.sink                       i_req,
    cga_rsp_if.source                     o_rsp,
    output logic [$clog2(CELL_COUNT)-1:0] o_rd_addr,
    input  logic [$clog2(CELL_COUNT)-1:0] i_link_rd,
    input  logic [cga_pkg::EPOCH_W-1:0]   i_epoch_rd,
    output logic                          o_wr_en,
    output logic [$clog2(CELL_COUNT)-1:0] o_wr_addr,
    output logic [$clog2(CELL_COUNT)-1:0] o_wr_link,
    output logic [cga_pkg::EPOCH_W-1:0]   o_wr_epoch
);

    localparam int IDX_W = $clog2(CELL_COUNT);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(CELL_COUNT - 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_shared;
    logic                           r_act, n_act;
    logic [cga_pkg::IDX_PORT_W-1:0] r_req, n_req;
    logic [IDX_W-1:0]               r_addr;
    logic [IDX_W-1:0]               r_head, n_head;
    logic [IDX_W-1:0]               r_cnt, n_cnt;

    logic                           r_out_valid, n_out_valid;
    cga_pkg::t_status               r_out_status, n_out_status;
    logic [cga_pkg::IDX_PORT_W-1:0] r_out_idx, n_out_idx;
    logic [cga_pkg::EPOCH_W-1:0]    r_out_epoch, n_out_epoch;
    logic [cga_pkg::FLAGS_W-1:0]    r_out_flags, n_out_flags;
    logic [cga_pkg::IDX_PORT_W-1:0] r_out_cnt, n_out_cnt;

    logic                           accept;
    logic                           bad_index;
    logic [cga_pkg::EPOCH_W-1:0]    bumped;
    logic [cga_pkg::FLAGS_W-1:0]    flags;

    assign i_req.ready = (r_state == S_IDLE) && i_init_done;
    assign accept      = i_req.valid && i_req.ready;
    assign bad_index   = (r_req == '0) || (32'(r_req) >= 32'(CELL_COUNT));
    assign bumped      = i_epoch_rd + 1'b1;
    assign flags       = r_shared ? (cga_pkg::FLAG_OBJ_SHARED | cga_pkg::FLAG_SHARED_EXPORT)
                                  : '0;

    // allocate reads the head cell, free reads the cell being returned
    assign o_rd_addr = !accept ? r_addr :
                       (i_req.action == cga_pkg::ACT_FREE) ? IDX_W'(i_req.cell_index) : r_head;

    assign o_wr_addr  = r_addr;
    assign o_wr_link  = r_head;
    assign o_wr_epoch = bumped;

    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_req        = r_req;
        n_head       = r_head;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_epoch  = r_out_epoch;
        n_out_flags  = r_out_flags;
        n_out_cnt    = r_out_cnt;
        o_wr_en      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act   = i_req.action;
                    n_req   = i_req.cell_index;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                    n_out_status = cga_pkg::ST_OK;
                    n_out_idx    = '0;
                    n_out_epoch  = '0;
                    n_out_flags  = '0;
                    if (r_act == cga_pkg::ACT_ALLOC) begin
                        if (r_cnt == '0) begin
                            n_out_status = cga_pkg::ST_FULL;
                        end else begin
                            n_head      = i_link_rd;
                            n_cnt       = r_cnt - 1'b1;
                            n_out_idx   = cga_pkg::IDX_PORT_W'(r_addr);
                            n_out_epoch = i_epoch_rd;
                            n_out_flags = flags;
                        end
                    end else if (r_cnt == LAST) begin
                        n_out_status = cga_pkg::ST_NONE_ALLOC;
                    end else if (bad_index) begin
                        n_out_status = cga_pkg::ST_BAD_INDEX;
                    end else begin
                        o_wr_en     = 1'b1;
                        n_head      = r_addr;
                        n_cnt       = r_cnt + 1'b1;
                        n_out_idx   = cga_pkg::IDX_PORT_W'(r_addr);
                        n_out_epoch = bumped;
                        n_out_flags = flags;
                    end
                    n_out_cnt = cga_pkg::IDX_PORT_W'(n_cnt);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shared    <= 1'b0;
            r_head      <= IDX_W'(1);
            r_cnt       <= LAST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_shared <= i_cfg_wdata;
            end
        end
        r_act        <= n_act;
        r_req        <= n_req;
        r_addr       <= o_rd_addr;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_epoch  <= n_out_epoch;
        r_out_flags  <= n_out_flags;
        r_out_cnt    <= n_out_cnt;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.cell_index_out = r_out_idx;
    assign o_rsp.cell_epoch     = r_out_epoch;
    assign o_rsp.cell_flags     = r_out_flags;
    assign o_rsp.free_count     = r_out_cnt;

endmodule

// File: rtl/core/generational_cell_allocator.sv
// Top level of the generational cell allocator: link and epoch RAMs, init sweep,
// allocate/free sequencer. Depends on cga_pkg, cga_if, cga_ram, cga_init, cga_ctrl.
//
//   channel   | dir | handshake           | payload
//   i_req     | in  | valid/ready         | action, cell_index
//   o_rsp     | out | valid/ready         | status, cell_index_out, cell_epoch,
//             |     |                     | cell_flags, free_count
//   i_cfg_*   | in  | write enable only   | page_shared
//
// Each request first reads the addressed cell (head on allocate) from both RAMs at the
// transfer edge, then an execute state writes back on free and loads the response. After
// reset an init sweep chains the link RAM and clears the epoch RAM; i_req.ready stays
// low until it ends. A stalled response holds the execute state; the next request is
// taken once it leaves.
module generational_cell_allocator #(
    parameter int CELL_COUNT = cga_pkg::CELL_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    cga_req_if.sink   i_req,
    cga_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(CELL_COUNT);

    logic                        init_we;
    logic [IDX_W-1:0]            init_addr;
    logic [IDX_W-1:0]            init_link;
    logic                        init_done;

    logic                        ctrl_we;
    logic [IDX_W-1:0]            ctrl_addr;
    logic [IDX_W-1:0]            ctrl_link;
    logic [cga_pkg::EPOCH_W-1:0] ctrl_epoch;

    logic [IDX_W-1:0]            rd_addr;
    logic [IDX_W-1:0]            link_rd;
    logic [cga_pkg::EPOCH_W-1:0] epoch_rd;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [IDX_W-1:0]            wr_link;
    logic [cga_pkg::EPOCH_W-1:0] wr_epoch;

    cga_init #(.CELL_COUNT(CELL_COUNT)) u_init (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_wr_en   (init_we),
        .o_wr_addr (init_addr),
        .o_wr_link (init_link),
        .o_done    (init_done)
    );

    cga_ctrl #(.CELL_COUNT(CELL_COUNT)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_init_done (init_done),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_rd_addr   (rd_addr),
        .i_link_rd   (link_rd),
        .i_epoch_rd  (epoch_rd),
        .o_wr_en     (ctrl_we),
        .o_wr_addr   (ctrl_addr),
        .o_wr_link   (ctrl_link),
        .o_wr_epoch  (ctrl_epoch)
    );

    assign wr_en    = init_we || ctrl_we;
    assign wr_addr  = init_we ? init_addr : ctrl_addr;
    assign wr_link  = init_we ? init_link : ctrl_link;
    assign wr_epoch = init_we ? '0 : ctrl_epoch;

    cga_ram #(.WIDTH(IDX_W), .DEPTH(CELL_COUNT)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_link),
        .i_raddr (rd_addr),
        .o_rdata (link_rd)
    );

    cga_ram #(.WIDTH(cga_pkg::EPOCH_W), .DEPTH(CELL_COUNT)) u_epoch_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_epoch),
        .i_raddr (rd_addr),
        .o_rdata (epoch_rd)
    );

    a_no_req_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> init_done)
        else $error("request taken before init sweep finished");

    a_single_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(init_we && ctrl_we))
        else $error("init sweep and sequencer write RAMs together");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous still executing");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != cga_pkg::ST_OK) |->
        (o_rsp.cell_index_out == '0 && o_rsp.cell_epoch == '0 && o_rsp.cell_flags == '0))
        else $error("error response carries nonzero cell fields");

endmodule

// File: tb/sv/tb_generational_cell_allocator.sv
// Self-checking testbench for generational_cell_allocator: random valid/ready traffic of
// allocate and free requests, each response checked against an in-bench free-list model.
// Depends on cga_pkg, cga_if and the allocator RTL.
module tb_generational_cell_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import cga_pkg::*;

    localparam int CELLS       = CELL_COUNT_DEF;
    localparam int ITEM_TARGET = 1150;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic                  action;
        logic [IDX_PORT_W-1:0] cell_index;
    } t_cell_req;

    typedef struct packed {
        t_status               status;
        logic [IDX_PORT_W-1:0] cell_id;
        logic [EPOCH_W-1:0]    epoch;
        logic [FLAGS_W-1:0]    flags;
        logic [IDX_PORT_W-1:0] free_cnt;
    } t_alloc_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    cga_req_if req_if ();
    cga_rsp_if rsp_if ();

    generational_cell_allocator #(
        .CELL_COUNT(CELLS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // copy 0 follows accepted transfers, copy 1 plans the stimulus
    logic [IDX_PORT_W-1:0] model_link  [2][CELLS];
    logic [EPOCH_W-1:0]    model_epoch [2][CELLS];
    logic [IDX_PORT_W-1:0] model_head  [2];
    int                    model_free  [2];
    logic                  model_shared[2];

    t_cell_req             pending_reqs[$];
    t_alloc_result         expected_results[$];
    logic [IDX_PORT_W-1:0] live_cells[$];

    int            issued_total   = 0;
    int            results_seen   = 0;
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            hold_trig      = 0;
    int            hold_ack       = 0;
    int            hold_left      = 0;
    int            send_gap;
    int            recv_gap;
    logic          send_idle_on   = 1'b1;
    logic          recv_idle_on   = 1'b1;
    logic          offering;
    t_cell_req     next_req;
    t_alloc_result want_result;

    function automatic t_alloc_result cell_op(int m, logic act, logic [IDX_PORT_W-1:0] req);
        t_alloc_result        r;
        int                   slot;
        logic [FLAGS_W-1:0]   fl;
        r  = '0;
        fl = model_shared[m] ? (FLAG_OBJ_SHARED | FLAG_SHARED_EXPORT) : '0;
        if (act == ACT_ALLOC) begin
            if (model_free[m] == 0) begin
                r.status = ST_FULL;
            end else begin
                slot          = int'(model_head[m]) % CELLS;
                model_head[m] = IDX_PORT_W'(int'(model_link[m][slot]) % CELLS);
                model_free[m] = model_free[m] - 1;
                r.status      = ST_OK;
                r.cell_id     = IDX_PORT_W'(slot);
                r.epoch       = model_epoch[m][slot];
                r.flags       = fl;
            end
        end else if (model_free[m] == CELLS - 1) begin
            r.status = ST_NONE_ALLOC;
        end else if (req == '0 || int'(req) >= CELLS) begin
            r.status = ST_BAD_INDEX;
        end else begin
            slot                 = int'(req);
            model_link[m][slot]  = model_head[m];
            model_head[m]        = req;
            model_epoch[m][slot] = model_epoch[m][slot] + 1'b1;
            model_free[m]        = model_free[m] + 1;
            r.status             = ST_OK;
            r.cell_id            = req;
            r.epoch              = model_epoch[m][slot];
            r.flags              = fl;
        end
        r.free_cnt = IDX_PORT_W'(model_free[m]);
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("ERROR %t result %0d %s: got %0d, want %0d", $realtime, results_seen,
                     what, got, want);
    endtask

    task automatic queue_req(logic act, logic [IDX_PORT_W-1:0] idx);
        t_cell_req     it;
        t_alloc_result r;
        it.action     = act;
        it.cell_index = idx;
        r = cell_op(1, act, idx);
        if (r.status == ST_OK) begin
            if (act == ACT_ALLOC) begin
                live_cells.push_back(r.cell_id);
            end else begin
                for (int k = 0; k < live_cells.size(); k++) begin
                    if (live_cells[k] == r.cell_id) begin
                        live_cells.delete(k);
                        break;
                    end
                end
            end
        end
        pending_reqs.push_back(it);
        issued_total++;
    endtask

    task automatic queue_alloc();
        queue_req(ACT_ALLOC, IDX_PORT_W'($urandom));
    endtask

    task automatic queue_live_free();
        int k;
        if (live_cells.size() == 0) begin
            queue_alloc();
        end else begin
            if ($urandom_range(0, 3) == 0) k = live_cells.size() - 1;
            else k = $urandom_range(0, live_cells.size() - 1);
            queue_req(ACT_FREE, live_cells[k]);
        end
    endtask

    task automatic wait_idle();
        while (results_seen != issued_total) @(posedge i_clk);
    endtask

    task automatic write_page_shared(logic value);
        @(posedge i_clk);
        i_cfg_we        <= 1'b1;
        i_cfg_wdata     <= value;
        model_shared[0]  = value;
        model_shared[1]  = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_trig != hold_ack) begin
            hold_ack  <= hold_trig;
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap = -1;
        end else begin
            offering = req_if.valid;
            if (req_if.valid && req_if.ready) begin
                expected_results.push_back(cell_op(0, req_if.action, req_if.cell_index));
                offering = 1'b0;
            end
            if (!offering && pending_reqs.size() != 0) begin
                if (send_gap < 0) send_gap = send_idle_on ? $urandom_range(0, 19) : 0;
                if (send_gap == 0) begin
                    next_req = pending_reqs.pop_front();
                    req_if.action     <= next_req.action;
                    req_if.cell_index <= next_req.cell_index;
                    offering = 1'b1;
                    send_gap = -1;
                end else begin
                    send_gap--;
                end
            end
            req_if.valid <= offering;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending", rsp_if.status, 0);
                end else begin
                    want_result = expected_results.pop_front();
                    if (rsp_if.status !== want_result.status)
                        report_mismatch("status", rsp_if.status, want_result.status);
                    if (rsp_if.cell_index_out !== want_result.cell_id)
                        report_mismatch("cell_index_out", rsp_if.cell_index_out,
                                        want_result.cell_id);
                    if (rsp_if.cell_epoch !== want_result.epoch)
                        report_mismatch("cell_epoch", rsp_if.cell_epoch, want_result.epoch);
                    if (rsp_if.cell_flags !== want_result.flags)
                        report_mismatch("cell_flags", rsp_if.cell_flags, want_result.flags);
                    if (rsp_if.free_count !== want_result.free_cnt)
                        report_mismatch("free_count", rsp_if.free_count, want_result.free_cnt);
                end
                recv_gap = recv_idle_on ? $urandom_range(0, 19) : 0;
            end else if (recv_gap > 0) begin
                recv_gap--;
            end
            rsp_if.ready <= (recv_gap == 0) && (hold_left == 0);
        end
    end

    initial begin
        int phase;
        int phase_end;
        int n;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= 1'b0;
        for (int m = 0; m < 2; m++) begin
            for (int i = 0; i < CELLS; i++) begin
                model_link[m][i]  = (i >= 1 && i + 1 < CELLS) ? IDX_PORT_W'(i + 1) : '0;
                model_epoch[m][i] = '0;
            end
            model_head[m]   = IDX_PORT_W'(1);
            model_free[m]   = CELLS - 1;
            model_shared[m] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_page_shared(1'b0);
        queue_req(ACT_FREE, 7'd5);
        queue_req(ACT_FREE, 7'd0);
        queue_alloc();
        queue_alloc();
        queue_req(ACT_FREE, 7'd0);
        queue_req(ACT_FREE, 7'd2);
        queue_alloc();
        queue_req(ACT_FREE, 7'd127);
        queue_req(ACT_FREE, 7'd127);
        queue_req(ACT_ALLOC, 7'd127);
        queue_req(ACT_ALLOC, 7'd0);
        queue_req(ACT_FREE, 7'd1);
        queue_req(ACT_FREE, 7'd85);
        queue_req(ACT_FREE, 7'd42);
        wait_idle();

        write_page_shared(1'b1);
        queue_alloc();
        queue_alloc();
        queue_req(ACT_FREE, 7'd0);
        queue_req(ACT_FREE, 7'd127);
        queue_alloc();
        queue_live_free();
        queue_req(ACT_FREE, 7'd64);

        phase = 0;
        while (issued_total < ITEM_TARGET) begin
            wait_idle();
            if (phase == 0) write_page_shared(1'b0);
            else write_page_shared(1'($urandom));
            send_idle_on = (phase % 3 != 1);
            recv_idle_on = (phase % 4 != 3);
            if (phase == 2) begin
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
                hold_trig++;
            end
            phase_end = issued_total + $urandom_range(120, 220);
            while (issued_total < phase_end && issued_total < ITEM_TARGET) begin
                n = $urandom_range(1, 30);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        repeat (n) queue_alloc();
                    end
                    4, 5, 6: begin
                        repeat (n) queue_live_free();
                    end
                    7: begin
                        repeat (n) begin
                            if ($urandom_range(0, 1) == 0) queue_alloc();
                            else queue_live_free();
                        end
                    end
                    8: begin
                        repeat (n % 12 + 1) queue_req(1'($urandom), IDX_PORT_W'($urandom));
                    end
                    default: begin
                        if ($urandom_range(0, 1) == 0) begin
                            while (model_free[1] > 0) queue_alloc();
                            repeat ($urandom_range(1, 3)) queue_alloc();
                        end else begin
                            while (live_cells.size() > 0 && model_free[1] < CELLS - 1)
                                queue_live_free();
                            repeat ($urandom_range(1, 2))
                                queue_req(ACT_FREE, IDX_PORT_W'($urandom));
                        end
                    end
                endcase
            end
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned", 0, expected_results.size());
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
